[rtl/pidwi_pkg.sv]
// pidwi_pkg: shared widths, reset values and register codes for the
// windowed-integral PID block. No dependencies.
package pidwi_pkg;

    localparam int POS_W      = 16;  // target / measured position
    localparam int ERR_W      = 17;  // signed position error
    localparam int GAIN_W     = 16;  // unsigned gains
    localparam int WLEN_W     = 5;   // window length register
    localparam int TORQUE_W   = 32;  // saturated output
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int WINDOW_DEF = 16;  // default ring depth
    localparam int PIPE_DEPTH = 4;   // beats that can be in flight

    localparam logic [WLEN_W-1:0] WLEN_RST = WLEN_W'(16);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P     = 2'd0,
        CFG_GAIN_I     = 2'd1,
        CFG_GAIN_D     = 2'd2,
        CFG_WINDOW_LEN = 2'd3
    } cfg_reg_t;

endpackage

[rtl/pid_windowed_integral.sv]
// pid_windowed_integral: PID controller with a moving-window integral term.
// Depends on pidwi_pkg and pidwi_ram.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-------------------------------
//  s_*     | in  | s_tvalid / s_tready       | s_tdata: target_pos, measured_pos
//  m_*     | out | m_tvalid / m_tready       | m_tdata: torque_cmd; m_tuser: overflow
//  cfg_*   | in  | cfg_valid / cfg_ready (=1)| cfg_index, cfg_data
//
// One beat per cycle sustained while m_tready is high; an accepted input beat
// passes through four register stages (input register, error/sum stage,
// multiply stage, sum/saturate output register) before m_tvalid rises. The
// ring read address is the next write index, so the registered read data
// matches the current slot and the running-sum update fits in a single stage.
// Reset clears the pipeline valids, the ring valid bits, the sum and the
// previous error at once. Each stage holds only while the one after it is
// full and stalled, so bubbles are squeezed out under m_tready low.
module pid_windowed_integral #(
    parameter int WINDOW = pidwi_pkg::WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2*pidwi_pkg::POS_W-1:0]       s_tdata,   // [15:0] target_pos, [31:16] measured_pos
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pidwi_pkg::TORQUE_W-1:0]      m_tdata,   // [31:0] torque_cmd (signed)
    output logic                                m_tuser,   // [0] overflow
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pidwi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pidwi_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pidwi_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = ERR_W + $clog2(WINDOW + 1);
    localparam int DIF_W = ERR_W + 1;
    localparam int P_W   = ERR_W + GAIN_W + 1;
    localparam int I_W   = SUM_W + GAIN_W + 1;
    localparam int D_W   = DIF_W + GAIN_W + 1;
    localparam int TOT_W = I_W + 2;
    localparam logic [8:0] WIN9 = 9'(WINDOW);

    // Configuration registers
    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [WLEN_W-1:0] wlen_reg;
    logic              cfg_we;
    logic              win_clear;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;
    assign win_clear = cfg_we && (cfg_index == CFG_WINDOW_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            wlen_reg   <= WLEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_GAIN_P:     gain_p_reg <= cfg_data;
                CFG_GAIN_I:     gain_i_reg <= cfg_data;
                CFG_GAIN_D:     gain_d_reg <= cfg_data;
                CFG_WINDOW_LEN: wlen_reg   <= cfg_data[WLEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Active window length clamped to 1..WINDOW
    logic [8:0] wlen9, act_len;
    assign wlen9 = {{(9-WLEN_W){1'b0}}, wlen_reg};

    always_comb
    begin
        if (wlen9 == 9'd0)
            act_len = 9'd1;
        else if (wlen9 > WIN9)
            act_len = WIN9;
        else
            act_len = wlen9;
    end

    // Pipeline valids and stage enables
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic en0, en1, en2, en3, commit;

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign s_tready = en0;
    assign commit   = v0_reg && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= s_tvalid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // Stage 0: input register
    logic [POS_W-1:0] tgt_reg, meas_reg;

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            tgt_reg  <= s_tdata[POS_W-1:0];
            meas_reg <= s_tdata[2*POS_W-1:POS_W];
        end
    end

    // Window state
    logic [IDX_W-1:0]        idx_reg, idx_next, idx_adv;
    logic [WINDOW-1:0]       vld_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_new;
    logic signed [ERR_W-1:0] prev_reg;
    logic                    byp_reg;
    logic [ERR_W-1:0]        byp_data_reg;
    logic [ERR_W-1:0]        ram_rdata;
    logic [8:0]              idx_inc;

    logic signed [ERR_W-1:0] err, old_err;
    logic signed [DIF_W-1:0] diff;

    assign err = ERR_W'({1'b0, tgt_reg}) - ERR_W'({1'b0, meas_reg});

    // Slot being replaced; empty slots read as zero
    always_comb
    begin
        if (!vld_reg[idx_reg])
            old_err = '0;
        else if (byp_reg)
            old_err = byp_data_reg;
        else
            old_err = ram_rdata;
    end

    assign sum_new = sum_reg + {{(SUM_W-ERR_W){err[ERR_W-1]}}, err}
                             - {{(SUM_W-ERR_W){old_err[ERR_W-1]}}, old_err};
    assign diff    = {err[ERR_W-1], err} - {prev_reg[ERR_W-1], prev_reg};

    // Next write index, wrapping at the active length
    assign idx_inc = {{(9-IDX_W){1'b0}}, idx_reg} + 9'd1;
    assign idx_adv = (idx_inc >= act_len) ? '0 : idx_inc[IDX_W-1:0];

    always_comb
    begin
        if (win_clear)
            idx_next = '0;
        else if (commit)
            idx_next = idx_adv;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            vld_reg  <= '0;
            sum_reg  <= '0;
            prev_reg <= '0;
            byp_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            byp_reg <= commit && (idx_reg == idx_next);
            if (win_clear)
            begin
                vld_reg <= '0;
                sum_reg <= '0;
            end
            else if (commit)
            begin
                vld_reg[idx_reg] <= 1'b1;
                sum_reg          <= sum_new;
            end
            if (commit)
                prev_reg <= err;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= err;
    end

    // Error ring storage; read address is the next write index
    pidwi_ram #(
        .WIDTH (ERR_W),
        .DEPTH (WINDOW),
        .ADDR_W(IDX_W)
    ) u_ring (
        .clk  (clk),
        .we   (commit),
        .waddr(idx_reg),
        .wdata(err),
        .raddr(idx_next),
        .rdata(ram_rdata)
    );

    // Stage 1: error, window sum, difference
    logic signed [ERR_W-1:0] err1_reg;
    logic signed [SUM_W-1:0] sum1_reg;
    logic signed [DIF_W-1:0] diff1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            err1_reg  <= err;
            sum1_reg  <= sum_new;
            diff1_reg <= diff;
        end
    end

    // Stage 2: gain products
    logic signed [GAIN_W:0] gp_s, gi_s, gd_s;
    logic signed [P_W-1:0]  prod_p;
    logic signed [I_W-1:0]  prod_i;
    logic signed [D_W-1:0]  prod_d;
    logic signed [P_W-1:0]  prod_p_reg;
    logic signed [I_W-1:0]  prod_i_reg;
    logic signed [D_W-1:0]  prod_d_reg;

    assign gp_s   = {1'b0, gain_p_reg};
    assign gi_s   = {1'b0, gain_i_reg};
    assign gd_s   = {1'b0, gain_d_reg};
    assign prod_p = gp_s * err1_reg;
    assign prod_i = gi_s * sum1_reg;
    assign prod_d = gd_s * diff1_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            prod_p_reg <= prod_p;
            prod_i_reg <= prod_i;
            prod_d_reg <= prod_d;
        end
    end

    // Stage 3: exact sum, saturate to 32 bits
    logic signed [TOT_W-1:0]    total;
    logic                       sat_pos, sat_neg;
    logic [TORQUE_W-1:0]        torque;
    logic [TORQUE_W-1:0]        torque_reg;
    logic                       ovf_reg;

    assign total = {{(TOT_W-P_W){prod_p_reg[P_W-1]}}, prod_p_reg}
                 + {{(TOT_W-I_W){prod_i_reg[I_W-1]}}, prod_i_reg}
                 + {{(TOT_W-D_W){prod_d_reg[D_W-1]}}, prod_d_reg};

    assign sat_pos = !total[TOT_W-1] && (|total[TOT_W-2:TORQUE_W-1]);
    assign sat_neg = total[TOT_W-1] && !(&total[TOT_W-2:TORQUE_W-1]);

    always_comb
    begin
        if (sat_pos)
            torque = {1'b0, {(TORQUE_W-1){1'b1}}};
        else if (sat_neg)
            torque = {1'b1, {(TORQUE_W-1){1'b0}}};
        else
            torque = total[TORQUE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            torque_reg <= torque;
            ovf_reg    <= sat_pos | sat_neg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = torque_reg;
    assign m_tuser  = ovf_reg;

endmodule

[rtl/pidwi_ram.sv]
// pidwi_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pidwi_ram #(
    parameter int WIDTH  = 17,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port (old data on same-address write)
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pidwi_checker.sv]
// pidwi_checker: port-level assertions for pid_windowed_integral, bound to it.
// Depends on pidwi_pkg.
module pidwi_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [pidwi_pkg::TORQUE_W-1:0]      m_tdata,
    input logic                                m_tuser
);
    import pidwi_pkg::*;

    localparam logic [TORQUE_W-1:0] T_MAX = {1'b0, {(TORQUE_W-1){1'b1}}};
    localparam logic [TORQUE_W-1:0] T_MIN = {1'b1, {(TORQUE_W-1){1'b0}}};

    // Beats accepted but not yet delivered
    logic [2:0] cnt_reg, cnt_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_tvalid & s_tready;
    assign out_beat = m_tvalid & m_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_beat && !out_beat)
            cnt_next = cnt_reg + 3'd1;
        else if (!in_beat && out_beat)
            cnt_next = cnt_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // No result shows up without a beat having gone in
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cnt_reg != 3'd0))
        else $error("result beat without a pending input beat");

    // Never more in flight than the pipeline holds
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(PIPE_DEPTH))
        else $error("more beats in flight than pipeline stages");

    // Overflow flag only comes with a saturated value
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == T_MAX || m_tdata == T_MIN))
        else $error("overflow flagged on an unsaturated torque");

    // Output is idle once reset has been seen at a clock edge
    a_rst_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("m_tvalid high during reset");

    // A stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind pid_windowed_integral pidwi_checker u_pidwi_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
